// File: hdl/utf8_validate_and_sanitize_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 sanitizer assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_VALIDATE_AND_SANITIZE_ASSERT_SVH
`define UTF8_VALIDATE_AND_SANITIZE_ASSERT_SVH

// same-cycle implication
`define U8S_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define U8S_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/u8s_pkg.sv
// ----------------------------------------------------------------------------
// u8s_pkg
// Types, constants and lead-byte decode for the UTF-8 sanitizer.
// ----------------------------------------------------------------------------
package u8s_pkg;

  localparam int unsigned FifoDepth = 2;

  localparam logic [7:0] LeadMin2   = 8'hC2;
  localparam logic [7:0] LeadE0     = 8'hE0;
  localparam logic [7:0] LeadED     = 8'hED;
  localparam logic [7:0] LeadF0     = 8'hF0;
  localparam logic [7:0] LeadF4     = 8'hF4;
  localparam logic [7:0] ContMin    = 8'h80;
  localparam logic [7:0] ContMax    = 8'hBF;
  localparam logic [7:0] LoE0       = 8'hA0;
  localparam logic [7:0] HiED       = 8'h9F;
  localparam logic [7:0] LoF0       = 8'h90;
  localparam logic [7:0] HiF4       = 8'h8F;
  localparam logic [7:0] RepByte0   = 8'hEF;
  localparam logic [7:0] RepByte1   = 8'hBF;
  localparam logic [7:0] RepByte2   = 8'hBD;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
    logic       stream_valid;
  } out_item_t;

  // one request's worth of output: [replacement] data bytes [replacement]
  typedef struct packed {
    logic            rep_a;
    logic            rep_b;
    logic [2:0]      n_data;
    logic [3:0][7:0] data;
    logic            last;
    logic            clean_end;
  } cmd_t;

  // sequence length of a lead byte, 0 when it cannot start one
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b < ContMin) begin
      len = 3'd1;
    end else if (b < LeadMin2) begin
      len = 3'd0;
    end else if (b < LeadE0) begin
      len = 3'd2;
    end else if (b < LeadF0) begin
      len = 3'd3;
    end else if (b <= LeadF4) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  function automatic logic [7:0] second_lo(input logic [7:0] lead);
    logic [7:0] lo;
    if (lead == LeadE0) begin
      lo = LoE0;
    end else if (lead == LeadF0) begin
      lo = LoF0;
    end else begin
      lo = ContMin;
    end
    return lo;
  endfunction

  function automatic logic [7:0] second_hi(input logic [7:0] lead);
    logic [7:0] hi;
    if (lead == LeadED) begin
      hi = HiED;
    end else if (lead == LeadF4) begin
      hi = HiF4;
    end else begin
      hi = ContMax;
    end
    return hi;
  endfunction

  function automatic logic [7:0] rep_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = RepByte0;
      2'd1:    r = RepByte1;
      default: r = RepByte2;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/u8s_front.sv
// ----------------------------------------------------------------------------
// u8s_front
// Accepts bytes, tracks the open sequence and issues output commands.
// ----------------------------------------------------------------------------
module u8s_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  u8s_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output u8s_pkg::cmd_t     q_cmd
);

  logic [2:0][7:0] held_r, held_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [2:0]      exp_r, exp_nxt;
  logic            err_r, err_nxt;

  logic [7:0] b;
  logic       last;
  logic       ok;
  logic [2:0] len;
  logic       do_lead;
  logic       rep_a, rep_b;
  logic [2:0] n_data;
  logic [3:0][7:0] data;
  logic       accept;

  assign b        = in_data.in_byte;
  assign last     = in_data.in_last;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign len      = u8s_pkg::lead_len(b);

  always_comb begin
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    exp_nxt  = exp_r;
    rep_a    = 1'b0;
    rep_b    = 1'b0;
    n_data   = 3'd0;
    data     = {4{b}};
    do_lead  = 1'b1;
    ok       = 1'b0;

    if (cnt_r != 2'd0) begin
      if (cnt_r == 2'd1) begin
        ok = (b >= u8s_pkg::second_lo(held_r[0])) && (b <= u8s_pkg::second_hi(held_r[0]));
      end else begin
        ok = (b[7:6] == 2'b10);
      end
      if (ok) begin
        do_lead = 1'b0;
        if (({1'b0, cnt_r} + 3'd1) >= exp_r) begin
          // sequence complete: held bytes then this one
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < cnt_r) begin
              data[i] = held_r[i];
            end
          end
          n_data  = {1'b0, cnt_r} + 3'd1;
          cnt_nxt = 2'd0;
          exp_nxt = 3'd0;
        end else begin
          held_nxt[cnt_r] = b;
          cnt_nxt         = cnt_r + 2'd1;
        end
      end else begin
        // broken prefix, then retry byte as a lead
        rep_a   = 1'b1;
        cnt_nxt = 2'd0;
        exp_nxt = 3'd0;
      end
    end

    if (do_lead) begin
      cnt_nxt = 2'd0;
      exp_nxt = 3'd0;
      if (len == 3'd1) begin
        n_data = 3'd1;
      end else if (len == 3'd0) begin
        rep_b = 1'b1;
      end else begin
        held_nxt[0] = b;
        cnt_nxt     = 2'd1;
        exp_nxt     = len;
      end
    end

    // cut off at end of stream
    if (last && (cnt_nxt != 2'd0)) begin
      rep_b   = 1'b1;
      cnt_nxt = 2'd0;
      exp_nxt = 3'd0;
    end

    err_nxt = last ? 1'b0 : (err_r | rep_a | rep_b);
  end

  assign q_cmd.rep_a     = rep_a;
  assign q_cmd.rep_b     = rep_b;
  assign q_cmd.n_data    = n_data;
  assign q_cmd.data      = data;
  assign q_cmd.last      = last;
  assign q_cmd.clean_end = last & ~(err_r | rep_a | rep_b);
  assign q_push          = accept && (rep_a || rep_b || (n_data != 3'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      exp_r <= 3'd0;
      err_r <= 1'b0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
      exp_r <= exp_nxt;
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule

// File: hdl/u8s_fifo.sv
// ----------------------------------------------------------------------------
// u8s_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module u8s_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  u8s_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output u8s_pkg::cmd_t head
);

  localparam int unsigned PtrW = $clog2(u8s_pkg::FifoDepth);
  localparam int unsigned CntW = $clog2(u8s_pkg::FifoDepth + 1);

  u8s_pkg::cmd_t mem_r [u8s_pkg::FifoDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CntW'(u8s_pkg::FifoDepth));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(u8s_pkg::FifoDepth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(u8s_pkg::FifoDepth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hdl/u8s_back.sv
// ----------------------------------------------------------------------------
// u8s_back
// Walks commands into the output register, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module u8s_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  u8s_pkg::cmd_t      q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output u8s_pkg::out_item_t out_data
);

  logic [2:0]         pos_r, pos_nxt;
  logic               out_valid_r, out_valid_nxt;
  u8s_pkg::out_item_t out_data_r, out_data_nxt;

  logic [2:0] off_a, off_b, total, j, k;
  logic       advance, final_one;
  logic [7:0] sel_byte;

  assign off_a     = q_head.rep_a ? 3'd3 : 3'd0;
  assign off_b     = q_head.rep_b ? 3'd3 : 3'd0;
  assign total     = off_a + q_head.n_data + off_b;
  assign final_one = (pos_r == (total - 3'd1));
  assign advance   = q_not_empty && (!out_valid_r || out_ready);
  assign q_pop     = advance && final_one;
  assign j         = pos_r - off_a;
  assign k         = j - q_head.n_data;

  always_comb begin
    if (q_head.rep_a && (pos_r < 3'd3)) begin
      sel_byte = u8s_pkg::rep_byte(pos_r[1:0]);
    end else if (j < q_head.n_data) begin
      sel_byte = q_head.data[j[1:0]];
    end else begin
      sel_byte = u8s_pkg::rep_byte(k[1:0]);
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      pos_nxt                   = final_one ? 3'd0 : pos_r + 3'd1;
      out_valid_nxt             = 1'b1;
      out_data_nxt.out_byte     = sel_byte;
      out_data_nxt.run_last     = final_one;
      out_data_nxt.stream_end   = final_one & q_head.last;
      out_data_nxt.stream_valid = final_one & q_head.clean_end;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/utf8_validate_and_sanitize.sv
// Path: a request is queued as a command, then leaves via the output register.
// Throughput: 1 input request per cycle while the queue is not full; the back end
//   sends 1 result byte per cycle unless out_ready stalls it; a request emits
//   0 to 6 bytes (a replacement is 3).
// Output rate is set by the single output register fed from the 2-entry queue.
// Reset: rst_n synchronous, active low; clears sequence state, queue and output valid.
// ----------------------------------------------------------------------------
// utf8_validate_and_sanitize
// UTF-8 stream sanitizer with maximal-subpart replacement (U+FFFD).
// ----------------------------------------------------------------------------
//
// Structure:
//   u8s_front - takes one byte per request, checks it against the open
//               sequence (lead range for the second byte, 10xxxxxx after),
//               and turns the outcome into a command:
//                 [EF BF BD] data bytes [EF BF BD]
//               The leading replacement covers a broken prefix; the trailing
//               one covers an invalid lead or a prefix cut off by in_last.
//               Commands with nothing to send are dropped here.
//   u8s_fifo  - two-entry command queue so the front keeps taking bytes
//               while the back is still expanding a replacement.
//   u8s_back  - steps through the head command, one byte a cycle unless stalled,
//               into the output register; tags run_last, stream_end, stream_valid.
//
// stream_valid is decided in the front from the running error flag plus any
// replacement in the current request, and the flag clears after a last byte.
module utf8_validate_and_sanitize (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  u8s_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output u8s_pkg::out_item_t out_data
);

  logic          q_push, q_full, q_pop, q_not_empty;
  u8s_pkg::cmd_t q_cmd, q_head;

  u8s_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  u8s_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  u8s_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// File: hdl/u8s_checker.sv
// ----------------------------------------------------------------------------
// u8s_checker
// Port-level checks on the sanitizer's result channel.
// ----------------------------------------------------------------------------
`include "utf8_validate_and_sanitize_assert.svh"

module u8s_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input u8s_pkg::out_item_t out_data
);

  // stalled result holds
  `U8S_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // end of stream only on the last byte of a request
  `U8S_ASSERT_IMPLIES(a_end_on_run_last, clk, rst_n, out_valid && out_data.stream_end, out_data.run_last, "stream_end without run_last")

  // valid flag only reported at end of stream
  `U8S_ASSERT_IMPLIES(a_valid_on_end, clk, rst_n, out_valid && out_data.stream_valid, out_data.stream_end, "stream_valid without stream_end")

endmodule

bind utf8_validate_and_sanitize u8s_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
